[hdl/utd_pkg.sv]
package utd_pkg;

	localparam int ByteW = 8;
	localparam int PendW = 3;

	// control characters allowed alongside printable ASCII
	localparam logic [ByteW-1:0] ChBel = 8'h07;
	localparam logic [ByteW-1:0] ChBs  = 8'h08;
	localparam logic [ByteW-1:0] ChHt  = 8'h09;
	localparam logic [ByteW-1:0] ChLf  = 8'h0A;
	localparam logic [ByteW-1:0] ChFf  = 8'h0C;
	localparam logic [ByteW-1:0] ChCr  = 8'h0D;
	localparam logic [ByteW-1:0] ChEsc = 8'h1B;
	localparam logic [ByteW-1:0] PrintLo = 8'h20;
	localparam logic [ByteW-1:0] PrintHi = 8'h7E;

	localparam logic [1:0] ContTag = 2'b10;
	localparam logic [PendW-1:0] LenBad = 3'd0;

	typedef struct packed {
		logic             zero;
		logic             ascii;
		logic             ascii_ok;
		logic             cont;
		logic [PendW-1:0] lead_len;
	} byte_class_t;

endpackage

[hdl/utd_byte_if.sv]
interface utd_byte_if;
	logic                       valid;
	logic                       ready;
	logic [utd_pkg::ByteW-1:0]  data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface

[hdl/utd_verdict_if.sv]
interface utd_verdict_if;
	logic valid;
	logic ready;
	logic is_utf8;

	modport source (output valid, output is_utf8, input ready);
	modport sink (input valid, input is_utf8, output ready);
endinterface

[hdl/utf8_text_detector.sv]
// channel   dir  payload           role
// in_byte   in   data_byte[7:0]    string bytes, zero ends a string
// verdict   out  is_utf8           one word per string, at the terminator
//
// One byte per cycle unless a verdict stalls. A byte is taken into the input
// register, then scanned against the string state; a terminator's verdict is
// loaded into the output register once that register is free.
// Reset clears the string state and both valid flags. A stalled verdict holds
// the terminator in the input register; non-terminator bytes still advance.
module utf8_text_detector (
	input  logic          clk,
	input  logic          arst_n,
	utd_byte_if.sink      in_byte,
	utd_verdict_if.source verdict
);
	import utd_pkg::*;

	logic             valid_s1;
	logic [ByteW-1:0] byte_s1;
	byte_class_t      cls;
	logic             out_free;
	logic             consume;
	logic             scan_verdict;
	logic             out_valid;
	logic             out_data;

	utd_byte_class u_class (
		.data_byte (byte_s1),
		.cls       (cls)
	);

	// advance unless a terminator waits for a full output register
	assign consume = valid_s1 && (!cls.zero || out_free);
	assign in_byte.ready = !valid_s1 || consume;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_byte.ready) begin
			valid_s1 <= in_byte.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_byte.ready && in_byte.valid) begin
			byte_s1 <= in_byte.data_byte;
		end
	end

	utd_scan u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (consume),
		.cls     (cls),
		.verdict (scan_verdict)
	);

	utd_out_reg u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (consume && cls.zero),
		.value  (scan_verdict),
		.take   (verdict.ready),
		.free   (out_free),
		.valid  (out_valid),
		.data   (out_data)
	);

	assign verdict.valid   = out_valid;
	assign verdict.is_utf8 = out_data;

endmodule

[hdl/utd_byte_class.sv]
module utd_byte_class (
	input  logic [utd_pkg::ByteW-1:0] data_byte,
	output utd_pkg::byte_class_t      cls
);
	import utd_pkg::*;

	always_comb begin
		cls.zero     = (data_byte == '0);
		cls.ascii    = ~data_byte[7];
		cls.ascii_ok = (data_byte inside {[PrintLo:PrintHi], ChBel, ChBs, ChHt, ChLf,
			ChFf, ChCr, ChEsc});
		cls.cont     = (data_byte[7:6] == ContTag);
		// continuation bytes a lead opens: one more than the ones after the 11 prefix
		if (!data_byte[5]) begin
			cls.lead_len = 3'd1;
		end else if (!data_byte[4]) begin
			cls.lead_len = 3'd2;
		end else if (!data_byte[3]) begin
			cls.lead_len = 3'd3;
		end else if (!data_byte[2]) begin
			cls.lead_len = 3'd4;
		end else if (!data_byte[1]) begin
			cls.lead_len = 3'd5;
		end else begin
			cls.lead_len = LenBad;
		end
	end

endmodule

[hdl/utd_scan.sv]
module utd_scan (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  utd_pkg::byte_class_t cls,
	output logic                 verdict
);
	import utd_pkg::*;

	logic [PendW-1:0] pending_q, pending_d;
	logic             seen_q, seen_d;
	logic             rejected_q, rejected_d;

	assign verdict = !rejected_q && seen_q;

	always_comb begin
		pending_d  = pending_q;
		seen_d     = seen_q;
		rejected_d = rejected_q;
		if (cls.zero) begin
			pending_d  = '0;
			seen_d     = 1'b0;
			rejected_d = 1'b0;
		end else if (rejected_q) begin
			// drop everything up to the terminator
		end else if (pending_q != '0) begin
			if (!cls.cont) begin
				rejected_d = 1'b1;
			end else begin
				pending_d = pending_q - 3'd1;
				if (pending_q == 3'd1) begin
					seen_d = 1'b1;
				end
			end
		end else if (cls.ascii) begin
			if (!cls.ascii_ok) begin
				rejected_d = 1'b1;
			end
		end else if (cls.cont || cls.lead_len == LenBad) begin
			rejected_d = 1'b1;
		end else begin
			pending_d = cls.lead_len;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q  <= '0;
			seen_q     <= 1'b0;
			rejected_q <= 1'b0;
		end else if (step) begin
			pending_q  <= pending_d;
			seen_q     <= seen_d;
			rejected_q <= rejected_d;
		end
	end

endmodule

[hdl/utd_text_detector_top_note.sv]
module utd_out_reg (
	input  logic clk,
	input  logic arst_n,
	input  logic load,
	input  logic value,
	input  logic take,
	output logic free,
	output logic valid,
	output logic data
);
	logic valid_q;
	logic data_q;

	assign valid = valid_q;
	assign data  = data_q;
	assign free  = !valid_q || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (take) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= value;
		end
	end

endmodule

[bench/testbench.sv]
// Tracks the string state for every byte word taken in and queues one verdict per terminator.
class utf8_verdict_board;
	logic [utd_pkg::PendW-1:0] pend;
	bit seen;
	bit bad;
	bit verdicts[$];
	int mismatches;

	function new();
		pend = '0;
		seen = 0;
		bad = 0;
		mismatches = 0;
	endfunction

	function int outstanding();
		return verdicts.size();
	endfunction

	function void note_byte(logic [utd_pkg::ByteW-1:0] b);
		int k;
		if (b == '0) begin
			verdicts.push_back(!bad && seen);
			pend = '0;
			seen = 0;
			bad = 0;
		end else if (!bad) begin
			if (pend != '0) begin
				if (b[7:6] != utd_pkg::ContTag) begin
					bad = 1;
				end else begin
					pend = pend - 1'b1;
					if (pend == '0)
						seen = 1;
				end
			end else if (!b[7]) begin
				if (!((b >= utd_pkg::PrintLo && b <= utd_pkg::PrintHi) ||
				      b == utd_pkg::ChBel || b == utd_pkg::ChBs || b == utd_pkg::ChHt ||
				      b == utd_pkg::ChLf || b == utd_pkg::ChFf || b == utd_pkg::ChCr ||
				      b == utd_pkg::ChEsc))
					bad = 1;
			end else if (!b[6]) begin
				bad = 1;
			end else begin
				// count leading ones: n ones open n-1 continuation bytes
				k = 7;
				while (k >= 0 && b[k])
					k--;
				if (7 - k >= 7) begin
					bad = 1;
				end else begin
					k = 7 - k - 1;
					pend = k[utd_pkg::PendW-1:0];
				end
			end
		end
	endfunction

	function void report(string what);
		if (mismatches < 10)
			$display("%0t: verdict mismatch: %s", $time, what);
		mismatches++;
	endfunction

	function void check_verdict(logic actual);
		bit want;
		if (verdicts.size() == 0) begin
			report($sformatf("unexpected word, actual is_utf8=%b", actual));
		end else begin
			want = verdicts.pop_front();
			if (actual !== want)
				report($sformatf("expected is_utf8=%b, actual is_utf8=%b", want, actual));
		end
	endfunction
endclass

module testbench;
	import utd_pkg::*;

	logic clk;
	logic arst_n;
	utd_byte_if    byte_ch();
	utd_verdict_if verdict_ch();

	utf8_verdict_board board;
	int  driven;
	int  idle_pct;
	bit  calm;
	int  sink_hold;

	utf8_text_detector u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_byte (byte_ch),
		.verdict (verdict_ch)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	initial begin
		#2000000;
		$display("testbench failed");
		$finish;
	end

	// sink side: stall in bursts of random length unless calm
	initial sink_hold = 0;
	always @(negedge clk) begin
		if (!calm && sink_hold == 0 && $urandom_range(0, 99) < idle_pct)
			sink_hold = $urandom_range(1, 4);
		if (sink_hold > 0) begin
			verdict_ch.ready = 1'b0;
			sink_hold--;
		end else begin
			verdict_ch.ready = 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && verdict_ch.valid && verdict_ch.ready)
			board.check_verdict(verdict_ch.is_utf8);
	end

	// Entered and left at a falling edge.
	task automatic send_byte(input logic [ByteW-1:0] b);
		int gap;
		if (!calm && $urandom_range(0, 99) < idle_pct) begin
			gap = $urandom_range(1, 4);
			byte_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		byte_ch.valid = 1'b1;
		byte_ch.data_byte = b;
		@(posedge clk);
		while (!byte_ch.ready)
			@(posedge clk);
		board.note_byte(b);
		driven++;
		@(negedge clk);
	endtask

	function automatic logic [ByteW-1:0] lead_byte(int n);
		logic [ByteW-1:0] lead;
		lead = 8'hFF << (7 - n);
		return lead | (ByteW'($urandom) & ((8'h01 << (6 - n)) - 8'h01));
	endfunction

	function automatic logic [ByteW-1:0] cont_byte();
		return 8'h80 | (ByteW'($urandom) & 8'h3F);
	endfunction

	function automatic logic [ByteW-1:0] text_byte();
		logic [ByteW-1:0] ctl [7];
		ctl = '{ChBel, ChBs, ChHt, ChLf, ChFf, ChCr, ChEsc};
		if ($urandom_range(0, 4) != 0)
			return ByteW'($urandom_range(PrintLo, PrintHi));
		return ctl[$urandom_range(0, 6)];
	endfunction

	initial begin
		logic [ByteW-1:0] directed [25];
		logic [ByteW-1:0] txt [$];
		int tokens;
		int dmg;
		int at;
		int n;
		int t;
		int j;

		board = new();
		driven = 0;
		idle_pct = 20;
		calm = 0;
		arst_n = 1'b0;
		byte_ch.valid = 1'b0;
		byte_ch.data_byte = '0;
		verdict_ch.ready = 1'b0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		// empty, plain text with a pair, longest sequence, cut-off, bad lead, bad continuation
		directed = '{
			8'h00,
			8'h09, 8'h0A, 8'h20, 8'h7E, 8'hC3, 8'hA9, 8'h00,
			8'hFD, 8'hBF, 8'h80, 8'h80, 8'h80, 8'h80, 8'h00,
			8'hE2, 8'h82, 8'h00,
			8'hFF, 8'hC3, 8'hA9, 8'h00,
			8'hC3, 8'h41, 8'h00
		};
		foreach (directed[i])
			send_byte(directed[i]);

		// hold the sender until the pipe has drained
		byte_ch.valid = 1'b0;
		while (board.outstanding() != 0)
			@(negedge clk);

		while (driven < 1950) begin
			calm = (driven > 1650);
			case ($urandom_range(0, 2))
				0: idle_pct = 0;
				1: idle_pct = 10;
				default: idle_pct = 35;
			endcase
			txt.delete();
			tokens = $urandom_range(0, 10);
			dmg = ($urandom_range(0, 9) < 3) ? $urandom_range(0, 2) : 3;
			at = $urandom_range(0, tokens);
			for (t = 0; t <= tokens; t++) begin
				if (t == at && dmg == 0)
					txt.push_back(ByteW'($urandom_range(1, 255)));
				if (t == at && dmg == 1) begin
					n = $urandom_range(1, 5);
					txt.push_back(lead_byte(n));
					for (j = $urandom_range(0, n - 1); j > 0; j--)
						txt.push_back(cont_byte());
				end
				if (t < tokens) begin
					if ($urandom_range(0, 9) < 4) begin
						txt.push_back(text_byte());
					end else begin
						n = $urandom_range(1, 5);
						txt.push_back(lead_byte(n));
						for (j = 0; j < n; j++)
							txt.push_back(cont_byte());
					end
				end
			end
			// drop the terminator into an open sequence
			if (dmg == 2) begin
				n = $urandom_range(1, 5);
				txt.push_back(lead_byte(n));
				for (j = $urandom_range(0, n - 1); j > 0; j--)
					txt.push_back(cont_byte());
			end
			txt.push_back('0);
			foreach (txt[i])
				send_byte(txt[i]);
		end

		byte_ch.valid = 1'b0;
		while (board.outstanding() != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);
		if (board.mismatches == 0 && board.outstanding() == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end
endmodule
